### rtl/core/mlm_pkg.sv
// Package for the mutex lock manager: transfer payload types, command and
// status codes, sequencer states and default sizes. No dependencies.
`timescale 1ns / 1ps

package mlm_pkg;

  localparam int DEF_NUM_LOCKS = 16;
  localparam int DEF_NUM_PROCS = 16;
  localparam int ID_W          = 4;
  localparam int PROC_W        = 4;
  localparam int STAT_W        = 2;

  typedef enum logic [1:0] {
    CMD_CREATE  = 2'd0,
    CMD_ACQUIRE = 2'd1,
    CMD_RELEASE = 2'd2,
    CMD_FREE    = 2'd3
  } cmd_t;

  localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_ERR     = 2'd1;
  localparam logic [STAT_W-1:0] STAT_BLOCKED = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISP,
    S_SCAN,
    S_EXEC,
    S_WAKE,
    S_DONE
  } state_t;

  typedef enum logic {
    Q_ENQ,
    Q_DEQ
  } qop_t;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [ID_W-1:0]   lock_id;
    logic [PROC_W-1:0] requester;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ID_W-1:0]   new_lock_id;
    logic              woken_valid;
    logic [PROC_W-1:0] woken_process;
  } out_item_t;

endpackage

### rtl/core/mlm_wait_ram.sv
// Waiter store: one FIFO area of NUM_PROCS entries per lock, single port,
// registered read. Depends on mlm_pkg.
`timescale 1ns / 1ps

module mlm_wait_ram #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             addr,
  input  logic [mlm_pkg::PROC_W-1:0] wdata,
  output logic [mlm_pkg::PROC_W-1:0] rdata
);
  import mlm_pkg::*;

  logic [PROC_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### rtl/core/mlm_qalu.sv
// Shared queue arithmetic: ring position for enqueue, head advance for
// dequeue, count step and full/empty flags. Depends on mlm_pkg.
`timescale 1ns / 1ps

module mlm_qalu #(
  parameter int NUM_PROCS = 16,
  parameter int PW        = 4,
  parameter int CW        = 5
) (
  input  mlm_pkg::qop_t op,
  input  logic [PW-1:0] head,
  input  logic [CW-1:0] cnt,
  output logic [PW-1:0] ptr,
  output logic [PW-1:0] head_nxt,
  output logic [CW-1:0] cnt_nxt,
  output logic          full,
  output logic          empty
);
  import mlm_pkg::*;

  localparam int SW = CW + 1;

  logic [SW-1:0] addend;
  logic [SW-1:0] sum;
  logic [SW-1:0] wrapped;

  always_comb begin
    addend   = (op == Q_DEQ) ? SW'(1) : SW'(cnt);
    sum      = SW'(head) + addend;
    wrapped  = (sum >= SW'(NUM_PROCS)) ? (sum - SW'(NUM_PROCS)) : sum;
    ptr      = (op == Q_DEQ) ? head : wrapped[PW-1:0];
    head_nxt = (op == Q_DEQ) ? wrapped[PW-1:0] : head;
    cnt_nxt  = (op == Q_DEQ) ? (cnt - CW'(1)) : (cnt + CW'(1));
    full     = (cnt == CW'(NUM_PROCS));
    empty    = (cnt == '0);
  end

endmodule

### rtl/core/mutex_lock_manager_core.sv
// Mutex lock manager top: sequencer, in-use bits, lock table memory and
// result register. Depends on mlm_pkg, mlm_qalu and mlm_wait_ram.
//
//   channel | ports                        | payload
//   input   | in_valid, in_stall, in_data  | cmd, lock_id, requester
//   output  | out_valid, out_stall, out_data | status, new_lock_id, woken_*
//
// Steps per input transfer: free and early errors go from dispatch to done;
// acquire and release pass through execute; release with handoff adds a wake
// step (waiter RAM read); create scans from slot 0 to the lowest free slot, or
// all NUM_LOCKS slots when full (one in-use bit tested per cycle). Waiter RAM
// has one port; the lock table has one write and one read port.
// rst_n clears the in-use bits and control; no clearing pass is needed.
// A stalled result sits in the output register; the next item is taken meanwhile.
`timescale 1ns / 1ps

module mutex_lock_manager_core #(
  parameter int NUM_LOCKS = mlm_pkg::DEF_NUM_LOCKS,
  parameter int NUM_PROCS = mlm_pkg::DEF_NUM_PROCS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  mlm_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output mlm_pkg::out_item_t out_data
);
  import mlm_pkg::*;

  localparam int LW  = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1;
  localparam int PW  = $clog2(NUM_PROCS);
  localparam int CW  = $clog2(NUM_PROCS + 1);
  localparam int AW  = (NUM_LOCKS * NUM_PROCS > 1) ? $clog2(NUM_LOCKS * NUM_PROCS) : 1;
  localparam int IXW = ((LW > ID_W) ? LW : ID_W) + 1;

  typedef struct packed {
    logic              ov;
    logic [PROC_W-1:0] oid;
    logic [PW-1:0]     head;
    logic [CW-1:0]     cnt;
  } ent_t;

  state_t            state_r, state_nxt;
  cmd_t              cmd_r;
  logic [ID_W-1:0]   id_r;
  logic [PROC_W-1:0] req_r;
  logic [LW-1:0]     scan_r, scan_nxt;
  logic [NUM_LOCKS-1:0] in_use_r, in_use_nxt;
  out_item_t         res_r, res_nxt;
  logic              out_valid_r;
  out_item_t         out_data_r;
  logic              out_load;

  logic [IXW-1:0]    id_ext;
  logic [IXW-1:0]    scan_ext;
  logic [LW-1:0]     id_idx;
  logic              id_ok;

  ent_t              tab_mem [NUM_LOCKS];
  ent_t              tab_rd_r;
  ent_t              tab_wdata;
  logic              tab_we;
  logic [LW-1:0]     tab_waddr;

  qop_t              q_op;
  logic [PW-1:0]     q_ptr;
  logic [PW-1:0]     q_head_nxt;
  logic [CW-1:0]     q_cnt_nxt;
  logic              q_full;
  logic              q_empty;

  logic              ram_we;
  logic [AW-1:0]     ram_addr;
  logic [PROC_W-1:0] ram_rdata;

  assign id_ext   = IXW'(id_r);
  assign id_idx   = id_ext[LW-1:0];
  assign id_ok    = (id_ext < IXW'(NUM_LOCKS));
  assign scan_ext = IXW'(scan_r);
  assign q_op     = (cmd_r == CMD_RELEASE) ? Q_DEQ : Q_ENQ;
  assign ram_addr = AW'(id_idx) * AW'(NUM_PROCS) + AW'(q_ptr);

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  mlm_qalu #(
    .NUM_PROCS (NUM_PROCS),
    .PW        (PW),
    .CW        (CW)
  ) u_qalu (
    .op       (q_op),
    .head     (tab_rd_r.head),
    .cnt      (tab_rd_r.cnt),
    .ptr      (q_ptr),
    .head_nxt (q_head_nxt),
    .cnt_nxt  (q_cnt_nxt),
    .full     (q_full),
    .empty    (q_empty)
  );

  mlm_wait_ram #(
    .DEPTH (NUM_LOCKS * NUM_PROCS),
    .AW    (AW)
  ) u_wait_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (req_r),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (tab_we) begin
      tab_mem[tab_waddr] <= tab_wdata;
    end
    tab_rd_r <= tab_mem[id_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_use_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      in_use_r <= in_use_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      cmd_r <= cmd_t'(in_data.cmd);
      id_r  <= in_data.lock_id;
      req_r <= in_data.requester;
    end
    scan_r <= scan_nxt;
    res_r  <= res_nxt;
    if (out_load) begin
      out_data_r <= res_r;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    scan_nxt   = scan_r;
    res_nxt    = res_r;
    in_use_nxt = in_use_r;
    tab_we     = 1'b0;
    tab_waddr  = id_idx;
    tab_wdata  = tab_rd_r;
    ram_we     = 1'b0;
    out_load   = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        res_nxt        = '0;
        res_nxt.status = STAT_ERR;
        scan_nxt       = '0;
        case (cmd_r)
          CMD_CREATE: begin
            state_nxt = S_SCAN;
          end
          CMD_FREE: begin
            if (id_ok) begin
              in_use_nxt[id_idx] = 1'b0;
              res_nxt.status     = STAT_OK;
            end
            state_nxt = S_DONE;
          end
          default: begin
            state_nxt = (id_ok && in_use_r[id_idx]) ? S_EXEC : S_DONE;
          end
        endcase
      end
      S_SCAN: begin
        if (!in_use_r[scan_r]) begin
          in_use_nxt[scan_r]  = 1'b1;
          tab_we              = 1'b1;
          tab_waddr           = scan_r;
          tab_wdata           = '0;
          res_nxt.status      = STAT_OK;
          res_nxt.new_lock_id = scan_ext[ID_W-1:0];
          state_nxt           = S_DONE;
        end else if (scan_r == LW'(NUM_LOCKS - 1)) begin
          state_nxt = S_DONE;
        end else begin
          scan_nxt = scan_r + LW'(1);
        end
      end
      S_EXEC: begin
        state_nxt = S_DONE;
        if (cmd_r == CMD_ACQUIRE) begin
          if (!tab_rd_r.ov) begin
            tab_we         = 1'b1;
            tab_wdata.ov   = 1'b1;
            tab_wdata.oid  = req_r;
            res_nxt.status = STAT_OK;
          end else if (tab_rd_r.oid != req_r && !q_full) begin
            ram_we         = 1'b1;
            tab_we         = 1'b1;
            tab_wdata.cnt  = q_cnt_nxt;
            res_nxt.status = STAT_BLOCKED;
          end
        end else begin
          if (tab_rd_r.ov && tab_rd_r.oid == req_r) begin
            if (q_empty) begin
              tab_we         = 1'b1;
              tab_wdata.ov   = 1'b0;
              tab_wdata.oid  = '0;
              res_nxt.status = STAT_OK;
            end else begin
              state_nxt = S_WAKE;
            end
          end
        end
      end
      S_WAKE: begin
        tab_we                = 1'b1;
        tab_wdata.oid         = ram_rdata;
        tab_wdata.head        = q_head_nxt;
        tab_wdata.cnt         = q_cnt_nxt;
        res_nxt.status        = STAT_OK;
        res_nxt.woken_valid   = 1'b1;
        res_nxt.woken_process = ram_rdata;
        state_nxt             = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

### bench/mlm_lock_checker.sv
// Transfer monitor and result predictor for mutex_lock_manager_core.
// Tracks the lock table, compares each result transfer with the oldest
// predicted one and counts failures. Depends on mlm_pkg.
`timescale 1ns / 1ps

module mlm_lock_checker (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  input  logic                                    in_stall,
  input  mlm_pkg::in_item_t                       in_data,
  input  logic                                    out_valid,
  input  logic                                    out_stall,
  input  mlm_pkg::out_item_t                      out_data,
  output int                                      fail_count,
  output int                                      results_due,
  output int                                      n_ok,
  output int                                      n_err,
  output int                                      n_blocked,
  output int                                      n_handoff,
  output logic [mlm_pkg::DEF_NUM_LOCKS-1:0]       lock_busy,
  output logic [mlm_pkg::DEF_NUM_LOCKS-1:0]       lock_held,
  output logic [mlm_pkg::DEF_NUM_LOCKS-1:0][3:0]  lock_holder
);

  import mlm_pkg::*;

  localparam int NL = DEF_NUM_LOCKS;
  localparam int NP = DEF_NUM_PROCS;

  logic [NL-1:0]             slot_busy;
  logic [NL-1:0]             slot_held;
  logic [NL-1:0][PROC_W-1:0] slot_owner;
  logic [NL-1:0][3:0]        wait_head;
  logic [NL-1:0][4:0]        wait_len;
  logic [PROC_W-1:0]         wait_store [NL][NP];

  out_item_t due_results [$];
  out_item_t want;

  assign lock_busy   = slot_busy;
  assign lock_held   = slot_held;
  assign lock_holder = slot_owner;

  function automatic void drop_slot(input int s);
    slot_busy[s]  = 1'b0;
    slot_held[s]  = 1'b0;
    slot_owner[s] = '0;
    wait_head[s]  = '0;
    wait_len[s]   = '0;
  endfunction

  function automatic out_item_t predict_lock_cmd(input in_item_t c);
    out_item_t         r;
    logic              found;
    logic [ID_W-1:0]   id;
    logic [3:0]        pos;
    logic [PROC_W-1:0] nxt;
    r        = '0;
    r.status = STAT_ERR;
    found    = 1'b0;
    id       = c.lock_id;
    case (cmd_t'(c.cmd))
      CMD_CREATE: begin
        for (int s = 0; s < NL; s++) begin
          if (!found && !slot_busy[s]) begin
            drop_slot(s);
            slot_busy[s]  = 1'b1;
            r.new_lock_id = ID_W'(s);
            r.status      = STAT_OK;
            found         = 1'b1;
          end
        end
      end
      CMD_FREE: begin
        drop_slot(int'(id));
        r.status = STAT_OK;
      end
      CMD_ACQUIRE: begin
        if (slot_busy[id]) begin
          if (!slot_held[id]) begin
            slot_held[id]  = 1'b1;
            slot_owner[id] = c.requester;
            r.status       = STAT_OK;
          end else if (slot_owner[id] != c.requester && wait_len[id] < NP) begin
            pos                 = wait_head[id] + wait_len[id][3:0];
            wait_store[id][pos] = c.requester;
            wait_len[id]        = wait_len[id] + 5'd1;
            r.status            = STAT_BLOCKED;
          end
        end
      end
      default: begin
        if (slot_busy[id] && slot_held[id] && slot_owner[id] == c.requester) begin
          r.status = STAT_OK;
          if (wait_len[id] == 0) begin
            slot_held[id]  = 1'b0;
            slot_owner[id] = '0;
          end else begin
            nxt             = wait_store[id][wait_head[id]];
            wait_head[id]   = wait_head[id] + 4'd1;
            wait_len[id]    = wait_len[id] - 5'd1;
            slot_owner[id]  = nxt;
            r.woken_valid   = 1'b1;
            r.woken_process = nxt;
          end
        end
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NL; s++) drop_slot(s);
      due_results.delete();
      fail_count  = 0;
      results_due = 0;
      n_ok        = 0;
      n_err       = 0;
      n_blocked   = 0;
      n_handoff   = 0;
    end else begin
      if (in_valid && !in_stall) due_results.push_back(predict_lock_cmd(in_data));
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          fail_count++;
          $display("%0t: result transfer with none pending: status=%0d new_id=%0d woken=%0b/%0d",
                   $time, out_data.status, out_data.new_lock_id, out_data.woken_valid,
                   out_data.woken_process);
        end else begin
          want = due_results.pop_front();
          if (out_data.status !== want.status || out_data.new_lock_id !== want.new_lock_id ||
              out_data.woken_valid !== want.woken_valid ||
              out_data.woken_process !== want.woken_process) begin
            fail_count++;
            $display("%0t: mismatch: expected status=%0d new_id=%0d woken=%0b/%0d, got status=%0d new_id=%0d woken=%0b/%0d",
                     $time, want.status, want.new_lock_id, want.woken_valid,
                     want.woken_process, out_data.status, out_data.new_lock_id,
                     out_data.woken_valid, out_data.woken_process);
          end
          case (want.status)
            STAT_OK:      n_ok++;
            STAT_BLOCKED: n_blocked++;
            default:      n_err++;
          endcase
          if (want.woken_valid) n_handoff++;
        end
      end
      results_due = due_results.size();
    end
  end

endmodule

### bench/tb_top.sv
// Top of the mutex_lock_manager_core bench: clock, reset, command stimulus,
// result-side stall pattern and verdict. Depends on mlm_pkg and mlm_lock_checker.
`timescale 1ns / 1ps

module tb_top;

  import mlm_pkg::*;

  localparam int NUM_CMDS    = 1050;
  localparam int CYCLE_LIMIT = 600000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  int fail_count, results_due, n_ok, n_err, n_blocked, n_handoff;
  logic [DEF_NUM_LOCKS-1:0]      lock_busy, lock_held;
  logic [DEF_NUM_LOCKS-1:0][3:0] lock_holder;

  int cmds_sent;
  int burst_left;
  int cycles;

  int stall_mode, stall_span, stall_run;

  mutex_lock_manager_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  mlm_lock_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .fail_count  (fail_count),
    .results_due (results_due),
    .n_ok        (n_ok),
    .n_err       (n_err),
    .n_blocked   (n_blocked),
    .n_handoff   (n_handoff),
    .lock_busy   (lock_busy),
    .lock_held   (lock_held),
    .lock_holder (lock_holder)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, results_due);
      $display("FAIL");
      $finish;
    end
  end

  // result-side back-pressure: four stall modes, each held for a random span
  always @(negedge clk) begin
    if (stall_span == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_span = $urandom_range(20, 120);
      stall_run  = 0;
    end
    stall_span--;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 2) == 0);
      2: begin
        if (stall_run == 0 && $urandom_range(0, 3) == 0) stall_run = $urandom_range(1, 8);
        out_stall <= (stall_run > 0);
        if (stall_run > 0) stall_run--;
      end
      default: out_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  task automatic issue(input cmd_t c, input logic [3:0] id, input logic [3:0] who);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_valid = 1'b1;
    in_data  = '{cmd: c, lock_id: id, requester: who};
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    burst_left--;
    cmds_sent++;
  endtask

  function automatic logic [3:0] pick_lock();
    return ($urandom_range(0, 99) < 80) ? 4'($urandom_range(0, 3)) : 4'($urandom_range(0, 15));
  endfunction

  function automatic logic [3:0] pick_releaser(input logic [3:0] id);
    return (lock_held[id] && $urandom_range(0, 99) < 80) ? lock_holder[id]
                                                          : 4'($urandom_range(0, 15));
  endfunction

  function automatic logic [3:0] pick_acquirer(input logic [3:0] id);
    return (lock_held[id] && $urandom_range(0, 99) < 10) ? lock_holder[id]
                                                          : 4'($urandom_range(0, 15));
  endfunction

  task automatic mixed_cmd();
    int         r;
    logic [3:0] id;
    r  = $urandom_range(0, 99);
    id = pick_lock();
    if (r < 10)      issue(CMD_CREATE, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
    else if (r < 55) issue(CMD_ACQUIRE, id, pick_acquirer(id));
    else if (r < 90) issue(CMD_RELEASE, id, pick_releaser(id));
    else             issue(CMD_FREE, id, 4'($urandom_range(0, 15)));
  endtask

  initial begin
    int         n;
    logic [3:0] id;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    cmds_sent  = 0;
    burst_left = 0;
    cycles     = 0;
    stall_span = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: unused slot, grant, owner re-acquire, non-owner release,
    // FIFO handoff with a repeated waiter, idle release, free with waiters
    issue(CMD_RELEASE, 4'd0, 4'd0);
    issue(CMD_ACQUIRE, 4'd0, 4'd0);
    issue(CMD_FREE, 4'd0, 4'd0);
    issue(CMD_CREATE, 4'd15, 4'd15);
    issue(CMD_ACQUIRE, 4'd0, 4'd15);
    issue(CMD_ACQUIRE, 4'd0, 4'd15);
    issue(CMD_RELEASE, 4'd0, 4'd5);
    issue(CMD_ACQUIRE, 4'd0, 4'd0);
    issue(CMD_ACQUIRE, 4'd0, 4'd10);
    issue(CMD_ACQUIRE, 4'd0, 4'd0);
    issue(CMD_RELEASE, 4'd0, 4'd15);
    issue(CMD_RELEASE, 4'd0, 4'd0);
    issue(CMD_RELEASE, 4'd0, 4'd10);
    issue(CMD_RELEASE, 4'd0, 4'd0);
    issue(CMD_RELEASE, 4'd0, 4'd0);
    issue(CMD_ACQUIRE, 4'd0, 4'd5);
    issue(CMD_ACQUIRE, 4'd0, 4'd6);
    issue(CMD_FREE, 4'd0, 4'd9);
    issue(CMD_RELEASE, 4'd0, 4'd5);
    issue(CMD_ACQUIRE, 4'd15, 4'd9);
    issue(CMD_CREATE, 4'd0, 4'd0);
    issue(CMD_CREATE, 4'd0, 4'd0);

    while (cmds_sent < NUM_CMDS) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          // contention: pile waiters onto one lock, sometimes past a full queue
          id = pick_lock();
          if (!lock_busy[id]) issue(CMD_CREATE, id, 4'($urandom_range(0, 15)));
          n = $urandom_range(3, 20);
          repeat (n) issue(CMD_ACQUIRE, id, pick_acquirer(id));
          repeat ($urandom_range(1, n + 2)) issue(CMD_RELEASE, id, pick_releaser(id));
        end
        8: repeat (6) issue(cmd_t'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                            4'($urandom_range(0, 15)));
        9: begin
          issue(CMD_FREE, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
          repeat ($urandom_range(1, 3)) issue(CMD_CREATE, 4'($urandom_range(0, 15)),
                                              4'($urandom_range(0, 15)));
        end
        default: repeat (20) mixed_cmd();
      endcase
    end
    in_valid = 1'b0;

    while (results_due != 0) @(negedge clk);
    repeat (30) @(negedge clk);

    $display("%0d lock commands issued over %0d cycles", cmds_sent, cycles);
    $display("results: %0d ok, %0d errors, %0d blocked, %0d handoffs to a waiter",
             n_ok, n_err, n_blocked, n_handoff);
    if (fail_count == 0 && results_due == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
